/* hdl/mersenne_twister_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the MT19937 generator
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH

// antecedent in this cycle, consequent in the next
`define MTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtg: next-cycle check failed");

// antecedent and consequent in the same cycle
`define MTG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtg: same-cycle check failed");

`endif

/* hdl/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and the tempering function of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int WORD_W          = 32;
	localparam int STATE_WORDS_DEF = 624;
	localparam int MID_OFFSET      = 397;

	localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'd2636928640;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'd4022730752;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW_RD,
		ST_DRAW_WR
	} mtg_state_t;

	typedef struct packed {
		logic seed_load;
		logic seed_step;
		logic draw_read;
		logic draw_commit;
	} mtg_cmd_t;

	typedef struct packed {
		logic seed_last;
	} mtg_stat_t;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* hdl/mtg_if.sv */
// ----------------------------------------------------------------------------
// mtg_req_if / mtg_rsp_if
// Valid/ready channels of the generator: command in, random word out.
// ----------------------------------------------------------------------------
interface mtg_req_if import mtg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [WORD_W-1:0] seed_value;

	modport source (output valid, output cmd, output seed_value, input ready);
	modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface mtg_rsp_if import mtg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

/* hdl/mtg_datapath.sv */
// ----------------------------------------------------------------------------
// mtg_datapath
// State table memory, seeding recurrence, incremental twist and tempering.
// ----------------------------------------------------------------------------
module mtg_datapath import mtg_pkg::*; #(
	parameter int STATE_WORDS = STATE_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtg_cmd_t          cmd,
	input  logic [WORD_W-1:0] seed_value,
	output mtg_stat_t         stat,
	output logic [WORD_W-1:0] random_word
);

	localparam int IDX_W = $clog2(STATE_WORDS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W:0]   WRAP     = (IDX_W + 1)'(STATE_WORDS);
	localparam logic [IDX_W:0]   MID      = (IDX_W + 1)'(MID_OFFSET);

	logic [WORD_W-1:0] mem [STATE_WORDS];

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              seeded_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] rd_nxt_q;
	logic [WORD_W-1:0] rd_mid_q;
	logic [WORD_W-1:0] word_q;

	logic [IDX_W-1:0]  nxt_idx;
	logic [IDX_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid_idx;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] seed_w;
	logic [WORD_W-1:0] y;
	logic [WORD_W-1:0] twist_w;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	always_comb begin
		nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		mid_sum = {1'b0, idx_q} + MID;
		mid_idx = (mid_sum >= WRAP) ? IDX_W'(mid_sum - WRAP) : mid_sum[IDX_W-1:0];

		mix    = prev_q ^ (prev_q >> 30);
		seed_w = (cnt_q == '0) ? prev_q
			: WORD_W'(mix * SEED_MULT) + WORD_W'(cnt_q);

		y       = (cur_q & UPPER_MASK) | (rd_nxt_q & LOWER_MASK);
		twist_w = rd_mid_q ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);

		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twist_w;
		if (cmd.seed_step) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = seed_w;
		end else if (cmd.draw_commit && seeded_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.draw_read) begin
			rd_nxt_q <= mem[nxt_idx];
			rd_mid_q <= mem[mid_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				idx_q    <= '0;
				cnt_q    <= '0;
				seeded_q <= 1'b1;
			end else begin
				if (cmd.draw_commit) begin
					idx_q <= nxt_idx;
				end
				if (cmd.seed_step) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			prev_q <= seed_value;
			cur_q  <= seed_value;
		end else begin
			if (cmd.seed_step) begin
				prev_q <= seed_w;
			end
			if (cmd.draw_commit) begin
				cur_q <= rd_nxt_q;
			end
		end
		if (cmd.draw_commit) begin
			word_q <= seeded_q ? temper(twist_w) : '0;
		end
	end

	assign stat.seed_last = (cnt_q == LAST_IDX);
	assign random_word    = word_q;

endmodule

/* hdl/mtg_ctrl.sv */
// ----------------------------------------------------------------------------
// mtg_ctrl
// Sequencer for seed and draw transactions and the result valid flag.
// ----------------------------------------------------------------------------
module mtg_ctrl import mtg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_cmd,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  mtg_stat_t stat,
	output mtg_cmd_t  cmd
);

	mtg_state_t state_q;
	mtg_state_t state_nxt;
	logic       rsp_valid_q;
	logic       acc;
	logic       slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.draw_commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		acc       = 1'b0;
		slot_ok   = !rsp_valid_q || rsp_ready;
		case (state_q)
			ST_IDLE, ST_DRAW_WR: begin
				req_ready        = 1'b1;
				acc              = req_valid;
				cmd.draw_commit  = (state_q == ST_DRAW_WR);
				state_nxt        = ST_IDLE;
				if (acc) begin
					if (req_cmd == CMD_DRAW) begin
						state_nxt = ST_DRAW_RD;
					end else begin
						cmd.seed_load = 1'b1;
						state_nxt     = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (stat.seed_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DRAW_RD: begin
				cmd.draw_read = 1'b1;
				if (slot_ok) begin
					state_nxt = ST_DRAW_WR;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* hdl/mersenne_twister_generator_unit.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit
// MT19937 32-bit pseudo-random word generator.
// ----------------------------------------------------------------------------
// request : valid/ready; cmd selects seed (seed_value used) or draw.
// response: valid/ready; one random_word per draw, none for a seed.
// A draw twists one table word in place (two memory reads, one write) and
// tempers it: once accepted it reads the table in ST_DRAW_RD, then in
// ST_DRAW_WR loads the result register and response.valid, and a following
// transaction is taken in that same state. A new draw can thus be accepted
// while the last one commits; the pace is set by the read and the write of
// the table memory, one step each. A seed, once accepted, writes one table
// word per cycle through the seeding multiplier, STATE_WORDS (624 by default) in all; request.ready is low meanwhile.
// After reset the table reads as unseeded: every draw returns 0 until the
// first seed, and no clearing pass runs.
// While response is stalled the result is held in its output register; a
// draw accepted meanwhile waits after its read step until the result is
// taken, and a seed proceeds regardless.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit import mtg_pkg::*; #(
	parameter int STATE_WORDS = STATE_WORDS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	mtg_req_if.sink       request,
	mtg_rsp_if.source     response
);

	mtg_cmd_t  cmd;
	mtg_stat_t stat;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_cmd   (request.cmd),
		.req_ready (request.ready),
		.rsp_valid (response.valid),
		.rsp_ready (response.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mtg_datapath #(
		.STATE_WORDS (STATE_WORDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (request.seed_value),
		.stat        (stat),
		.random_word (response.random_word)
	);

endmodule

/* hdl/mtg_checker.sv */
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_unit_macros.svh"

module mtg_checker import mtg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_cmd,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [WORD_W-1:0] rsp_word
);

	logic req_acc;

	assign req_acc = req_valid && req_ready;

	`MTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
	`MTG_ASSERT_SAME(a_rsp_fall, $fell(rsp_valid), $past(rsp_ready))
	`MTG_ASSERT_NEXT(a_seed_busy, req_acc && req_cmd == CMD_SEED, !req_ready)
	`MTG_ASSERT_NEXT(a_draw_busy, req_acc && req_cmd == CMD_DRAW, !req_ready)
	`MTG_ASSERT_NEXT(a_busy_no_rsp, rsp_valid && rsp_ready && !req_ready, !rsp_valid)

endmodule

bind mersenne_twister_generator_unit mtg_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.req_cmd   (request.cmd),
	.rsp_valid (response.valid),
	.rsp_ready (response.ready),
	.rsp_word  (response.random_word)
);

/* dv/mersenne_twister_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit_tb
// Self-checking testbench of the MT19937 generator. Seed and draw
// transactions are sent with random gaps, and the response side stalls at
// random. Each draw is predicted from a model of the 624-word table and the
// tempering, and each returned word is checked in order against it.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit_tb;
	import mtg_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TABLE_WORDS = STATE_WORDS_DEF;

	logic clk = 1'b0;
	logic arst_n;

	mtg_req_if request_chan ();
	mtg_rsp_if response_chan ();

	mersenne_twister_generator_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_chan),
		.response (response_chan)
	);

	logic [WORD_W-1:0] twister_words [TABLE_WORDS];
	int unsigned       word_index;
	logic [WORD_W-1:0] expected_words [$];

	int unsigned burst_left;
	int unsigned stall_phase_left;
	int unsigned stall_mode;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned draws_sent;
	int unsigned seeds_sent;
	int unsigned twist_count;
	int unsigned words_checked;

	always #CLK_HALF clk = ~clk;

	function automatic void reseed_table(input logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] prev;
		logic [WORD_W-1:0] step;
		twister_words[0] = seed;
		for (int i = 1; i < TABLE_WORDS; i++) begin
			prev = twister_words[i-1];
			step = i;
			twister_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + step;
		end
		word_index = 0;
	endfunction

	function automatic void twist_table();
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] w;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			y = (twister_words[i] & UPPER_MASK) |
				(twister_words[(i + 1) % TABLE_WORDS] & LOWER_MASK);
			w = twister_words[(i + MID_OFFSET) % TABLE_WORDS] ^ (y >> 1);
			if (y[0]) begin
				w = w ^ MATRIX_A;
			end
			twister_words[i] = w;
		end
		twist_count++;
	endfunction

	function automatic logic [WORD_W-1:0] next_tempered_word();
		logic [WORD_W-1:0] y;
		if (word_index == 0) begin
			twist_table();
		end
		y = twister_words[word_index];
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		word_index = (word_index + 1) % TABLE_WORDS;
		return y;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_transaction(input logic cmd, input logic [WORD_W-1:0] seed);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				request_chan.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		request_chan.valid      <= 1'b1;
		request_chan.cmd        <= cmd;
		request_chan.seed_value <= seed;
		@(posedge clk);
		while (!request_chan.ready) begin
			@(posedge clk);
		end
		if (cmd == CMD_SEED) begin
			reseed_table(seed);
			seeds_sent++;
		end else begin
			expected_words.push_back(next_tempered_word());
			draws_sent++;
		end
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_draws(input int unsigned count);
		repeat (count) send_transaction(CMD_DRAW, $urandom());
	endtask

	// Hold the request side idle until every outstanding draw has returned.
	task automatic wait_drained();
		request_chan.valid <= 1'b0;
		@(negedge clk);
		while (expected_words.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_unseeded_draws();
		send_transaction(CMD_DRAW, 32'h0000_0000);
		send_transaction(CMD_DRAW, 32'hffff_ffff);
		send_transaction(CMD_DRAW, $urandom());
	endtask

	task automatic test_seed_extremes();
		send_transaction(CMD_SEED, 32'h0000_0000);
		send_draws(2);
		send_transaction(CMD_SEED, 32'hffff_ffff);
		send_draws(2);
		send_transaction(CMD_SEED, 32'd5489);
		send_draws(2);
		send_transaction(CMD_SEED, $urandom());
		send_transaction(CMD_SEED, $urandom());
		send_draws(2);
	endtask

	task automatic test_index_wrap();
		send_transaction(CMD_SEED, $urandom());
		send_draws(300);
		wait_drained();
		send_draws(400);
	endtask

	task automatic test_random_stream();
		repeat (1300) begin
			if ($urandom_range(0, 119) == 0) begin
				send_transaction(CMD_SEED, $urandom());
			end else begin
				send_transaction(CMD_DRAW, $urandom());
			end
		end
	endtask

	// Response stall pattern: phases of full rate, random, and heavy back-pressure.
	always @(negedge clk) begin
		if (stall_phase_left == 0) begin
			stall_mode       = $urandom_range(0, 2);
			stall_phase_left = $urandom_range(1, 60);
		end
		stall_phase_left--;
		case (stall_mode)
			0: begin
				response_chan.ready <= 1'b1;
			end
			1: begin
				response_chan.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				response_chan.ready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && response_chan.valid && response_chan.ready) begin
			if (expected_words.size() == 0) begin
				$error("random_word with no draw outstanding: actual %h",
					response_chan.random_word);
				error_count++;
			end else begin
				if (response_chan.random_word !== expected_words[0]) begin
					$error("random_word mismatch: expected %h, actual %h",
						expected_words[0], response_chan.random_word);
					error_count++;
				end
				void'(expected_words.pop_front());
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding",
				cycle_count, expected_words.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n                  = 1'b0;
		request_chan.valid      = 1'b0;
		request_chan.cmd        = CMD_DRAW;
		request_chan.seed_value = '0;
		response_chan.ready     = 1'b0;
		burst_left              = 0;
		stall_phase_left        = 0;
		stall_mode              = 0;
		error_count             = 0;
		cycle_count             = 0;
		draws_sent              = 0;
		seeds_sent              = 0;
		twist_count             = 0;
		words_checked           = 0;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			twister_words[i] = '0;
		end
		word_index = 0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_unseeded_draws();
		test_seed_extremes();
		test_index_wrap();
		test_random_stream();

		wait_drained();
		repeat (700) @(posedge clk);

		$display("Sent %0d draws and %0d seeds; %0d words checked across %0d table twists.",
			draws_sent, seeds_sent, words_checked, twist_count);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/mtg_pkg.sv
hdl/mtg_if.sv
hdl/mtg_datapath.sv
hdl/mtg_ctrl.sv
hdl/mersenne_twister_generator_unit.sv
hdl/mtg_checker.sv
dv/mersenne_twister_generator_unit_tb.sv
